[rtl/core/a85lw_pkg.sv]
`default_nettype none

package a85lw_pkg;

    // Printable characters produced by the encoder.
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_Z     = 8'h7A;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    // Line width after reset and the narrowest width the wrap logic honors.
    localparam logic [7:0] LINE_WIDTH_RESET = 8'd64;
    localparam logic [7:0] LINE_WIDTH_MIN   = 8'd3;

    // Multiplicative inverse of 85 modulo 2**32, used for exact division.
    localparam logic [31:0] INV85 = 32'hFCFCFCFD;

    localparam int DIGITS = 5;

    // One base-85 digit value, 0..84, before the printable offset.
    typedef logic [6:0] digit_t;

    // Digits of one group, index 0 is the most significant.
    typedef digit_t [DIGITS-1:0] digits_t;

    // Per-group control carried alongside the digits.
    typedef struct packed {
        logic [2:0] ndig;
        logic       is_z;
        logic       fin;
    } grp_ctl_t;

    typedef struct packed {
        logic [31:0] quo;
        digit_t      rem;
    } div85_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MAIN,
        SEQ_WRAP,
        SEQ_TNL,
        SEQ_TILDE,
        SEQ_GT
    } seq_state_t;

    // Divide by 85. Since 256 = 1 mod 255, the byte sum gives the value mod 255,
    // hence mod 85; the quotient then follows exactly from the inverse of 85.
    function automatic div85_t div85(input logic [31:0] q);
        logic [9:0] s;
        logic [8:0] s2;
        digit_t     r;
        div85_t     res;
        s  = {2'b00, q[7:0]} + {2'b00, q[15:8]} + {2'b00, q[23:16]} + {2'b00, q[31:24]};
        s2 = {1'b0, s[7:0]} + {7'b0, s[9:8]};
        if (s2 >= 9'd255)
        begin
            r = 7'(s2 - 9'd255);
        end
        else if (s2 >= 9'd170)
        begin
            r = 7'(s2 - 9'd170);
        end
        else if (s2 >= 9'd85)
        begin
            r = 7'(s2 - 9'd85);
        end
        else
        begin
            r = s2[6:0];
        end
        res.rem = r;
        res.quo = (q - {25'b0, r}) * INV85;
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ascii85_line_wrapped_encoder.sv]
// ASCII85 encoder with line wrapping and a "~>" trailer.
//
// Input channel (in_valid/in_ready): one item is a group of up to four bytes,
// data_word with the first byte in bits 31..24, byte_count valid bytes and
// final_group. A group of fewer than four bytes always ends the stream.
// Output channel (out_valid/out_ready): one character per item transfer;
// last_char marks the final character caused by an input item.
// Configuration channel (cfg_valid/cfg_ready): writes line_width; cfg_ready is
// always high. Write it only while the encoder is idle.
//
// An accepted item passes through the input register, four divide-by-85 stages,
// the character sequencer and the output register.
// Throughput: one character per cycle while out_ready is high. An item yields
// 1 or 2 characters for 'z', 5 to 7 for a full group and up to 9 for a final
// group. The character sequencer sets these numbers.
// Reset: line width 64, column 0, all stages empty.
// Receiver stall: the output register holds its character; up to six more
// items are taken into the pipeline before in_ready drops.
`default_nettype none

module ascii85_line_wrapped_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  line_width,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        final_group,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_char,
    output logic             last_char
);

    // Configuration register.
    logic [7:0] width_reg;

    // Pipeline valid bits, quotients, digits and group control.
    logic                   v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [31:0]            q0_reg;
    logic [25:0]            q1_reg;
    logic [19:0]            q2_reg;
    logic [12:0]            q3_reg;
    a85lw_pkg::digits_t     dg1_reg, dg2_reg, dg3_reg, dg4_reg;
    a85lw_pkg::grp_ctl_t    ctl0_reg, ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic                   rdy1, rdy2, rdy3, rdy4;
    a85lw_pkg::div85_t      dv0, dv1, dv2, dv3;

    // Input preparation.
    logic [2:0]             cnt_c;
    logic [31:0]            word_m;
    a85lw_pkg::grp_ctl_t    ctl_in;

    // Character sequencer.
    a85lw_pkg::seq_state_t  state_reg, state_next;
    a85lw_pkg::digits_t     dg_reg;
    a85lw_pkg::grp_ctl_t    ctl_reg;
    logic [2:0]             idx_reg, idx_next;
    logic [7:0]             col_reg, col_next;
    logic [7:0]             col_inc;
    logic [7:0]             w_eff, wm1, wm2;
    logic                   more;
    logic                   emit;
    logic                   seq_take;
    logic [7:0]             ch;
    logic                   ch_last;
    logic                   wrap;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_char_reg;
    logic                   last_char_reg;

    assign cfg_ready = 1'b1;

    // Line width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= a85lw_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            width_reg <= line_width;
        end
    end

    // Clamp the byte count, clear unused bytes and classify the group.
    always_comb
    begin
        cnt_c = (byte_count > 3'd4) ? 3'd4 : byte_count;
        case (cnt_c)
            3'd0:    word_m = 32'd0;
            3'd1:    word_m = {data_word[31:24], 24'd0};
            3'd2:    word_m = {data_word[31:16], 16'd0};
            3'd3:    word_m = {data_word[31:8], 8'd0};
            default: word_m = data_word;
        endcase
        ctl_in.fin  = final_group || (cnt_c != 3'd4);
        ctl_in.is_z = (cnt_c == 3'd4) && (data_word == 32'd0);
        if (cnt_c == 3'd4)
        begin
            ctl_in.ndig = 3'd5;
        end
        else if (cnt_c == 3'd0)
        begin
            ctl_in.ndig = 3'd0;
        end
        else
        begin
            ctl_in.ndig = cnt_c + 3'd1;
        end
    end

    // Stall chain: a stage takes new data when it is empty or its data moves on.
    assign rdy4     = !v4_reg || seq_take;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = !v0_reg || rdy1;

    // One division by 85 per stage; the remainders are the digits, least
    // significant first, and the last quotient is the leading digit.
    assign dv0 = a85lw_pkg::div85(q0_reg);
    assign dv1 = a85lw_pkg::div85({6'd0, q1_reg});
    assign dv2 = a85lw_pkg::div85({12'd0, q2_reg});
    assign dv3 = a85lw_pkg::div85({19'd0, q3_reg});

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                v0_reg <= in_valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Pipeline payload; the lower digit slots are filled by the later stages.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            q0_reg   <= word_m;
            ctl0_reg <= ctl_in;
        end
        if (rdy1 && v0_reg)
        begin
            q1_reg   <= dv0.quo[25:0];
            dg1_reg  <= {dv0.rem, 28'd0};
            ctl1_reg <= ctl0_reg;
        end
        if (rdy2 && v1_reg)
        begin
            q2_reg   <= dv1.quo[19:0];
            dg2_reg  <= {dg1_reg[4], dv1.rem, 21'd0};
            ctl2_reg <= ctl1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            q3_reg   <= dv2.quo[12:0];
            dg3_reg  <= {dg2_reg[4:3], dv2.rem, 14'd0};
            ctl3_reg <= ctl2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            dg4_reg  <= {dg3_reg[4:2], dv3.rem, dv3.quo[6:0]};
            ctl4_reg <= ctl3_reg;
        end
    end

    // Effective wrap points.
    assign w_eff   = (width_reg < a85lw_pkg::LINE_WIDTH_MIN) ? a85lw_pkg::LINE_WIDTH_MIN
                                                             : width_reg;
    assign wm1     = w_eff - 8'd1;
    assign wm2     = w_eff - 8'd2;
    assign col_inc = col_reg + 8'd1;
    assign more    = !ctl_reg.is_z && ((idx_reg + 3'd1) < ctl_reg.ndig);

    // The sequencer emits when it holds a group and the output register frees up.
    assign emit     = (state_reg != a85lw_pkg::SEQ_IDLE) && (!out_valid_reg || out_ready);
    assign seq_take = v4_reg && ((state_reg == a85lw_pkg::SEQ_IDLE) || (emit && ch_last));

    // Sequencer next state, column tracking and character selection.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        col_next   = col_reg;
        ch         = a85lw_pkg::CHAR_NL;
        ch_last    = 1'b0;
        wrap       = 1'b0;
        case (state_reg)
            a85lw_pkg::SEQ_IDLE:
            begin
                state_next = a85lw_pkg::SEQ_IDLE;
            end
            a85lw_pkg::SEQ_MAIN:
            begin
                ch   = ctl_reg.is_z ? a85lw_pkg::CHAR_Z
                                    : ({1'b0, dg_reg[idx_reg]} + a85lw_pkg::CHAR_BANG);
                wrap = ctl_reg.is_z ? (col_inc >= wm1) : (col_inc >= w_eff);
                if (wrap)
                begin
                    state_next = a85lw_pkg::SEQ_WRAP;
                    col_next   = 8'd0;
                end
                else if (more)
                begin
                    state_next = a85lw_pkg::SEQ_MAIN;
                    idx_next   = idx_reg + 3'd1;
                    col_next   = col_inc;
                end
                else if (ctl_reg.fin)
                begin
                    state_next = (col_inc > wm2) ? a85lw_pkg::SEQ_TNL : a85lw_pkg::SEQ_TILDE;
                    col_next   = col_inc;
                end
                else
                begin
                    state_next = a85lw_pkg::SEQ_IDLE;
                    col_next   = col_inc;
                    ch_last    = 1'b1;
                end
            end
            a85lw_pkg::SEQ_WRAP:
            begin
                ch = a85lw_pkg::CHAR_NL;
                if (more)
                begin
                    state_next = a85lw_pkg::SEQ_MAIN;
                    idx_next   = idx_reg + 3'd1;
                end
                else if (ctl_reg.fin)
                begin
                    // The column is zero here, so no extra newline precedes the trailer.
                    state_next = a85lw_pkg::SEQ_TILDE;
                end
                else
                begin
                    state_next = a85lw_pkg::SEQ_IDLE;
                    ch_last    = 1'b1;
                end
            end
            a85lw_pkg::SEQ_TNL:
            begin
                ch         = a85lw_pkg::CHAR_NL;
                state_next = a85lw_pkg::SEQ_TILDE;
            end
            a85lw_pkg::SEQ_TILDE:
            begin
                ch         = a85lw_pkg::CHAR_TILDE;
                state_next = a85lw_pkg::SEQ_GT;
            end
            a85lw_pkg::SEQ_GT:
            begin
                ch         = a85lw_pkg::CHAR_GT;
                state_next = a85lw_pkg::SEQ_IDLE;
                col_next   = 8'd0;
                ch_last    = 1'b1;
            end
            default:
            begin
                state_next = a85lw_pkg::SEQ_IDLE;
            end
        endcase
        if (!emit)
        begin
            state_next = state_reg;
            idx_next   = idx_reg;
            col_next   = col_reg;
        end
        // A new group starts at its first digit, or at the trailer or its newline when empty.
        if (seq_take)
        begin
            idx_next = 3'd0;
            if (ctl4_reg.is_z || (ctl4_reg.ndig != 3'd0))
            begin
                state_next = a85lw_pkg::SEQ_MAIN;
            end
            else
            begin
                state_next = (col_next > wm2) ? a85lw_pkg::SEQ_TNL : a85lw_pkg::SEQ_TILDE;
            end
        end
    end

    // Sequencer control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= a85lw_pkg::SEQ_IDLE;
            idx_reg   <= 3'd0;
            col_reg   <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            col_reg   <= col_next;
        end
    end

    // Sequencer group payload.
    always_ff @(posedge clk)
    begin
        if (seq_take)
        begin
            dg_reg  <= dg4_reg;
            ctl_reg <= ctl4_reg;
        end
    end

    // Output register valid.
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_char_reg  <= ch;
            last_char_reg <= ch_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;

    // The trailer always leaves the column at zero.
    a_col_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (state_reg == a85lw_pkg::SEQ_GT)) |=> (col_reg == 8'd0))
        else $error("column not cleared after trailer");

    // Digit emission never runs past the digits of the group.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == a85lw_pkg::SEQ_MAIN) |-> (ctl_reg.is_z || (idx_reg < ctl_reg.ndig)))
        else $error("digit index beyond group length");

    // An empty input register always accepts.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v0_reg |-> in_ready)
        else $error("input stalled with empty input register");

    // The sequencer loads only a valid group.
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        seq_take |-> v4_reg)
        else $error("sequencer loaded from an empty stage");

endmodule

`default_nettype wire

[dv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The encoder never yields more characters than this for one item.
    localparam int MAX_CHARS_PER_GROUP = 9;
    localparam int HOLD_OFF_CYCLES = 240;

    // One expected character together with its end-of-item flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } a85_char_t;

    // Tracks line width and column, and holds the characters still owed by the encoder.
    class a85_scoreboard;
        logic [7:0] width_reg;
        logic [7:0] column;
        a85_char_t  expected_chars[$];
        a85_char_t  group_chars[$];
        int         errors;

        function new();
            width_reg = a85lw_pkg::LINE_WIDTH_RESET;
            column = 8'd0;
            errors = 0;
        endfunction

        function void set_width(logic [7:0] w);
            width_reg = w;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void put_char(logic [7:0] ch);
            a85_char_t c;
            if (group_chars.size() < MAX_CHARS_PER_GROUP)
            begin
                c.ch = ch;
                c.last = 1'b0;
                group_chars.push_back(c);
            end
        endfunction

        // A digit advances the column and wraps the line at the full width.
        function void put_digit(logic [7:0] ch, int unsigned wrap);
            put_char(ch);
            column = column + 8'd1;
            if (column >= wrap)
            begin
                put_char(a85lw_pkg::CHAR_NL);
                column = 8'd0;
            end
        endfunction

        // Works out the characters that one accepted group must produce.
        function void note_group(logic [31:0] word, logic [2:0] count, logic fin);
            int unsigned wrap;
            int unsigned nbytes;
            int unsigned ndig;
            int unsigned v;
            logic        ends;
            logic [7:0]  digits [5];
            a85_char_t   c;
            int          i;

            wrap = (width_reg < a85lw_pkg::LINE_WIDTH_MIN) ? a85lw_pkg::LINE_WIDTH_MIN
                                                           : width_reg;
            nbytes = (count > 3'd4) ? 4 : count;
            ends = fin;
            v = word;

            // A short group always ends the stream; its unused bytes count as zero.
            if (nbytes < 4)
            begin
                ends = 1'b1;
                v = (nbytes == 0) ? 0 : (word & (32'hFFFFFFFF << (8 * (4 - nbytes))));
            end

            group_chars.delete();
            if (nbytes == 4 && v == 0)
            begin
                // An all-zero full group is a single 'z', which wraps one column early.
                put_char(a85lw_pkg::CHAR_Z);
                column = column + 8'd1;
                if (column >= wrap - 1)
                begin
                    put_char(a85lw_pkg::CHAR_NL);
                    column = 8'd0;
                end
            end
            else if (nbytes > 0)
            begin
                for (i = 0; i < 5; i++)
                begin
                    digits[4 - i] = 8'(v % 85) + a85lw_pkg::CHAR_BANG;
                    v = v / 85;
                end
                ndig = (nbytes == 4) ? 5 : nbytes + 1;
                for (i = 0; i < int'(ndig); i++)
                    put_digit(digits[i], wrap);
            end

            // The trailer may need a newline of its own to fit on the line.
            if (ends)
            begin
                if (column > wrap - 2)
                    put_char(a85lw_pkg::CHAR_NL);
                put_char(a85lw_pkg::CHAR_TILDE);
                put_char(a85lw_pkg::CHAR_GT);
                column = 8'd0;
            end

            if (group_chars.size() > 0)
            begin
                c = group_chars.pop_back();
                c.last = 1'b1;
                group_chars.push_back(c);
            end
            foreach (group_chars[j])
                expected_chars.push_back(group_chars[j]);
        endfunction

        // Compares one received character with the oldest one owed.
        function void check_char(logic [7:0] ch, logic last);
            a85_char_t c;
            if (expected_chars.size() == 0)
            begin
                $error("out_char: expected none, actual %02h", ch);
                errors++;
                return;
            end
            c = expected_chars.pop_front();
            if (ch !== c.ch)
            begin
                $error("out_char: expected %02h, actual %02h", c.ch, ch);
                errors++;
            end
            if (last !== c.last)
            begin
                $error("last_char: expected %0b, actual %0b", c.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_width;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        final_group;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_char;
    logic        last_char;

    a85_scoreboard sb = new();

    bit no_gaps;
    int items_sent;
    int hold_reqs;
    int hold_seen;
    int stall_left;
    int cycle_no;

    ascii85_line_wrapped_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .line_width  (cfg_width),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .final_group (final_group),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_char   (last_char)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Offers one group, possibly after a few idle cycles, and waits for it to be taken.
    task automatic send_item(logic [31:0] word, logic [2:0] count, logic fin);
        if (!no_gaps)
        begin
            while ($urandom_range(99) < 13)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        data_word = word;
        byte_count = count;
        final_group = fin;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_group(word, count, fin);
        items_sent++;
        @(negedge clk);
    endtask

    // Changes the line width once every owed character has come out.
    task automatic set_line_width(logic [7:0] w);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_width = w;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_width(w);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // A run of groups with random content, mostly closed by some kind of final group.
    task automatic send_stream(int groups);
        logic [31:0] w;
        int          k;
        int          pick;
        for (k = 0; k < groups; k++)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_item($urandom(), 3'($urandom_range(7, 5)), 1'($urandom_range(1)));
            end
            else
            begin
                w = ($urandom_range(99) < 12) ? 32'd0 : $urandom();
                send_item(w, 3'd4, 1'b0);
            end
        end
        pick = $urandom_range(9);
        if (pick < 4)
            send_item($urandom(), 3'd4, 1'b1);
        else if (pick < 8)
            send_item($urandom(), 3'($urandom_range(3)), 1'($urandom_range(1)));
        else if (pick == 8)
            send_item(32'd0, 3'd4, 1'b1);
    endtask

    task automatic run_random(int n);
        int target;
        target = items_sent + n;
        while (items_sent < target)
            send_stream($urandom_range(8));
    endtask

    // Receiver: random stalls, periodic calm windows, long hold-offs.
    initial
    begin
        out_ready = 1'b0;
        hold_seen = 0;
        stall_left = 0;
        cycle_no = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cycle_no++;
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if ((cycle_no % 600) < 150)
            begin
                out_ready = 1'b1;
            end
            else
            begin
                out_ready = ($urandom_range(99) >= 13);
            end
        end
    end

    // Every character taken by the receiver is checked at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_char(out_char, last_char);
    end

    // Main sequence: directed groups, then random streams at several line widths.
    initial
    begin
        int k;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_width = a85lw_pkg::LINE_WIDTH_RESET;
        in_valid = 1'b0;
        data_word = 32'd0;
        byte_count = 3'd0;
        final_group = 1'b0;
        no_gaps = 1'b0;
        items_sent = 0;
        hold_reqs = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed groups at the reset width.
        send_item(32'h00000000, 3'd4, 1'b0);
        send_item(32'hFFFFFFFF, 3'd4, 1'b0);
        send_item(32'h00000001, 3'd4, 1'b0);
        send_item(32'h12345678, 3'd5, 1'b0);
        send_item(32'h00000000, 3'd7, 1'b0);
        send_item(32'hDEADBEEF, 3'd6, 1'b0);
        send_item(32'h00000000, 3'd4, 1'b1);
        send_item(32'h00000000, 3'd0, 1'b1);
        send_item(32'h00000000, 3'd0, 1'b0);
        send_item(32'hA1B2C3D4, 3'd1, 1'b0);
        send_item(32'hFFFFFFFF, 3'd2, 1'b1);
        send_item(32'h00000000, 3'd2, 1'b1);
        send_item(32'hFFFFFFFF, 3'd4, 1'b1);
        for (k = 0; k < 12; k++)
            send_item($urandom() | 32'h1, 3'd4, 1'b0);
        send_item(32'h89ABCDEF, 3'd3, 1'b0);

        // Narrowest widths.
        set_line_width(8'd2);
        run_random(35);
        set_line_width(a85lw_pkg::LINE_WIDTH_MIN);
        run_random(35);

        // Widest line, left open so the next width starts past its wrap point.
        set_line_width(8'd255);
        run_random(30);
        for (k = 0; k < 20; k++)
            send_item($urandom() | 32'h1, 3'd4, 1'b0);
        set_line_width(8'd6);
        run_random(35);

        // Back to the reset width while the receiver holds off and the sender never pauses.
        set_line_width(a85lw_pkg::LINE_WIDTH_RESET);
        no_gaps = 1'b1;
        hold_reqs++;
        run_random(40);
        no_gaps = 1'b0;

        repeat (3)
        begin
            set_line_width(8'($urandom_range(255, 2)));
            run_random(20);
        end

        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("** ascii85_line_wrapped_encoder: PASSED **");
        else
            $display("** ascii85_line_wrapped_encoder: FAILED **");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5000000;
        $display("** ascii85_line_wrapped_encoder: FAILED **");
        $finish;
    end

endmodule

[ascii85_line_wrapped_encoder.f]
rtl/core/a85lw_pkg.sv
rtl/core/ascii85_line_wrapped_encoder.sv
dv/tb_top.sv
